// ===== sv/lcgr_pkg.sv =====
package lcgr_pkg;

  // generator constants
  localparam logic [63:0] LCG_MULT   = 64'h5851_F42D_4C95_7F2D;
  localparam int          DRAW_SHIFT = 33;
  localparam int          DRAW_W     = 64 - DRAW_SHIFT;
  localparam int          SPAN_W     = 32;
  localparam int          STEP_W     = $clog2(DRAW_W);

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DSTART,
    S_DIV,
    S_OUT
  } state_t;

  // divider control and status
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic done;
  } div_sts_t;

endpackage

// ===== sv/lcgr_if.sv =====
// request word: mode and range bounds
interface lcgr_req_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [31:0] range_min;
  logic signed [31:0] range_max;

  modport source (output valid, mode, range_min, range_max, input ready);
  modport sink   (input valid, mode, range_min, range_max, output ready);
endinterface

// result word
interface lcgr_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic               range_error;

  modport source (output valid, value, range_error, input ready);
  modport sink   (input valid, value, range_error, output ready);
endinterface

// seed register write
interface lcgr_cfg_if;
  logic        valid;
  logic        ready;
  logic [63:0] start_seed;

  modport source (output valid, start_seed, input ready);
  modport sink   (input valid, start_seed, output ready);
endinterface

// ===== sv/lcgr_divider.sv =====
// Restoring divider, one quotient bit per cycle; only the remainder is kept.
module lcgr_divider (
  input  logic                             clk,
  input  logic                             rst,
  input  lcgr_pkg::div_ctl_t               ctl,
  input  logic [lcgr_pkg::DRAW_W-1:0]      dividend,
  input  logic [lcgr_pkg::SPAN_W-1:0]      divisor,
  output lcgr_pkg::div_sts_t               sts,
  output logic [lcgr_pkg::SPAN_W-1:0]      remainder
);

  logic                             busy;
  logic                             done;
  logic [lcgr_pkg::STEP_W-1:0]      step;
  logic [lcgr_pkg::DRAW_W-1:0]      dvd;
  logic [lcgr_pkg::SPAN_W-1:0]      dvs;
  logic [lcgr_pkg::SPAN_W:0]        trial;
  logic                             fits;

  // shift in next dividend bit and try the subtract
  assign trial = {remainder, dvd[lcgr_pkg::DRAW_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == lcgr_pkg::STEP_W'(lcgr_pkg::DRAW_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      dvd       <= dividend;
      dvs       <= divisor;
      remainder <= '0;
    end else if (busy) begin
      dvd       <= dvd << 1;
      remainder <= fits ? lcgr_pkg::SPAN_W'(trial - {1'b0, dvs})
                        : trial[lcgr_pkg::SPAN_W-1:0];
    end
  end

  assign sts.done = done;

endmodule

// ===== sv/lcg_random_with_range.sv =====
// 64-bit LCG random source with optional range reduction. Each request word
// advances the state (state * 6364136223846793005 + 1 mod 2^64) and returns
// the top 31 bits, or in range mode range_min + draw mod (range_max -
// range_min); an empty or inverted range returns range_min with range_error
// set. The 64-bit product is built from three 32x32 partial products on one
// shared multiplier; the modulo runs on a bit-serial restoring divider.
// req.ready is low from accept until the result is loaded into the output
// register, which holds it so the next request is taken while it waits. A
// seed write reloads the state and is taken only while idle.
module lcg_random_with_range (
  input  logic          clk,
  input  logic          rst,
  lcgr_cfg_if.sink      cfg,
  lcgr_req_if.sink      req,
  lcgr_rsp_if.source    rsp
);

  lcgr_pkg::state_t          st, st_next;
  lcgr_pkg::div_ctl_t        div_ctl;
  lcgr_pkg::div_sts_t        div_sts;

  logic [63:0]               gen_state;
  logic [63:0]               acc;
  logic [63:0]               prod;
  logic [1:0]                cnt;
  logic                      mode_q;
  logic [31:0]               lo_q;
  logic [lcgr_pkg::SPAN_W-1:0] span_q;
  logic                      err_q;

  logic                      req_acc;
  logic                      ld_out;
  logic [31:0]               mul_a, mul_b;
  logic [63:0]               mul_p;
  logic [63:0]               acc_sum;
  logic [lcgr_pkg::SPAN_W-1:0] div_rem;
  logic [31:0]               res_value;
  logic [31:0]               req_blo, req_bhi;

  assign cfg.ready = (st == lcgr_pkg::S_IDLE);
  assign req.ready = (st == lcgr_pkg::S_IDLE);
  assign req_acc   = req.valid && req.ready;

  // offset-binary bounds: signed order becomes unsigned order
  assign req_blo = {~req.range_min[31], req.range_min[30:0]};
  assign req_bhi = {~req.range_max[31], req.range_max[30:0]};

  // shared multiplier: low 64 bits from aL*mL, aL*mH, aH*mL
  always_comb begin
    case (cnt)
      2'd0:    begin mul_a = gen_state[31:0];  mul_b = lcgr_pkg::LCG_MULT[31:0];  end
      2'd1:    begin mul_a = gen_state[31:0];  mul_b = lcgr_pkg::LCG_MULT[63:32]; end
      2'd2:    begin mul_a = gen_state[63:32]; mul_b = lcgr_pkg::LCG_MULT[31:0];  end
      default: begin mul_a = '0;               mul_b = '0;                        end
    endcase
  end

  assign mul_p   = mul_a * mul_b;
  assign acc_sum = (cnt == 2'd1) ? acc + prod : acc + {prod[31:0], 32'd0};

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= lcgr_pkg::S_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_comb begin
    st_next       = st;
    ld_out        = 1'b0;
    div_ctl.start = 1'b0;
    case (st)
      lcgr_pkg::S_IDLE: begin
        if (req_acc) st_next = lcgr_pkg::S_MUL;
      end
      lcgr_pkg::S_MUL: begin
        if (cnt == 2'd3) begin
          st_next = (mode_q && !err_q) ? lcgr_pkg::S_DSTART : lcgr_pkg::S_OUT;
        end
      end
      lcgr_pkg::S_DSTART: begin
        div_ctl.start = 1'b1;
        st_next       = lcgr_pkg::S_DIV;
      end
      lcgr_pkg::S_DIV: begin
        if (div_sts.done) st_next = lcgr_pkg::S_OUT;
      end
      lcgr_pkg::S_OUT: begin
        if (!rsp.valid || rsp.ready) begin
          ld_out  = 1'b1;
          st_next = lcgr_pkg::S_IDLE;
        end
      end
      default: st_next = lcgr_pkg::S_IDLE;
    endcase
  end

  // request capture and product accumulation
  always_ff @(posedge clk) begin
    if (req_acc) begin
      mode_q <= req.mode;
      lo_q   <= req.range_min;
      span_q <= req_bhi - req_blo;
      err_q  <= req.mode && (req_blo >= req_bhi);
      cnt    <= '0;
      acc    <= 64'd1;
    end else if (st == lcgr_pkg::S_MUL) begin
      prod <= mul_p;
      cnt  <= cnt + 1'b1;
      if (cnt != 2'd0) acc <= acc_sum;
    end
  end

  // generator state: reset, seed write, or new product
  always_ff @(posedge clk) begin
    if (rst) begin
      gen_state <= '0;
    end else if (cfg.valid && cfg.ready) begin
      gen_state <= cfg.start_seed;
    end else if (st == lcgr_pkg::S_MUL && cnt == 2'd3) begin
      gen_state <= acc_sum;
    end
  end

  lcgr_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .ctl       (div_ctl),
    .dividend  (gen_state[63:lcgr_pkg::DRAW_SHIFT]),
    .divisor   (span_q),
    .sts       (div_sts),
    .remainder (div_rem)
  );

  // result select
  always_comb begin
    if (!mode_q) begin
      res_value = {1'b0, gen_state[63:lcgr_pkg::DRAW_SHIFT]};
    end else if (err_q) begin
      res_value = lo_q;
    end else begin
      res_value = lo_q + div_rem;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (ld_out) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      rsp.value       <= res_value;
      rsp.range_error <= err_q;
    end
  end

endmodule

// ===== sv/lcgr_checker.sv =====
// Port-level checks for the random source.
module lcgr_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [31:0] rsp_value,
  input logic        rsp_range_error
);

  // a waiting result word holds until taken
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value)
                                && $stable(rsp_range_error))
    else $error("result word changed while stalled");

  // one request at a time: busy right after accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  // no result appears right after a request into an empty output
  a_latency: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && !rsp_valid |=> !rsp_valid)
    else $error("result appeared too early");

  // reset empties the output register
  a_reset: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid after reset");

endmodule

bind lcg_random_with_range lcgr_checker u_lcgr_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_value       (rsp.value),
  .rsp_range_error (rsp.range_error)
);
